[sv/sg_pkg.sv]
// Package for the Scharr gradient unit: widths, CORDIC angle table and the
// shared stage word type. Used by every module under sv/ except sg_ram.
package sg_pkg;

  localparam int MaxWidthDefault  = 4096;
  localparam int AngleFracDefault = 13;
  localparam int CordicSteps      = 30;
  localparam int CfgIdxW          = 1;
  localparam int CfgDataW         = 13;
  localparam logic [CfgIdxW-1:0] RegLineWidth   = 1'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 1'd1;

  // x and y carry gradients scaled by 2^20; 13 bits of value plus growth
  localparam int XyW = 36;
  localparam int ZW  = 34;
  localparam logic signed [ZW-1:0] PiQ30 = 34'sd3373259426;

  // One word moving along the CORDIC chain
  typedef struct packed {
    logic                  vld;
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic signed [ZW-1:0]  z;
    logic                  zero;
    logic [24:0]           grad_sq;
    logic [11:0]           col;
    logic [11:0]           row;
    logic                  fend;
  } stage_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
      3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
      6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
      9: v = 32'h001FFFFD; 10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
      18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
      21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
      24: v = 32'h0000003F; 25: v = 32'h0000001F; 26: v = 32'h0000000F;
      27: v = 32'h00000008; 28: v = 32'h00000004; 29: v = 32'h00000002;
      default: v = 32'h0;
    endcase
    return $signed({2'b00, v});
  endfunction

endpackage

[sv/sg_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module sg_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Read returns the old word when both ports hit one address
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end
endmodule

[sv/sg_cordic_cell.sv]
// One CORDIC vectoring micro-rotation, registered, with enable.
// Depends on sg_pkg.
module sg_cordic_cell #(
  parameter int Step = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  sg_pkg::stage_t din,
  output sg_pkg::stage_t dout
);
  logic signed [sg_pkg::XyW-1:0] dx;
  logic signed [sg_pkg::XyW-1:0] dy;
  sg_pkg::stage_t                nxt;

  // Rotate toward y = 0; y >= 0 counts as positive
  always_comb begin
    dx  = din.y >>> Step;
    dy  = din.x >>> Step;
    nxt = din;
    if (!din.y[sg_pkg::XyW-1]) begin
      nxt.x = din.x + dx;
      nxt.y = din.y - dy;
      nxt.z = din.z + sg_pkg::atan_q30(Step);
    end else begin
      nxt.x = din.x - dx;
      nxt.y = din.y + dy;
      nxt.z = din.z - sg_pkg::atan_q30(Step);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout.vld <= din.vld;
    end
    if (en) begin
      dout.x       <= nxt.x;
      dout.y       <= nxt.y;
      dout.z       <= nxt.z;
      dout.zero    <= nxt.zero;
      dout.grad_sq <= nxt.grad_sq;
      dout.col     <= nxt.col;
      dout.row     <= nxt.row;
      dout.fend    <= nxt.fend;
    end
  end
endmodule

[sv/sg_window.sv]
// Raster front end: counters, two line stores, 3x3 window, Scharr sums and
// the first registered CORDIC word. Depends on sg_pkg and sg_ram.
module sg_window #(
  parameter int MaxWidth = sg_pkg::MaxWidthDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_take,
  input  logic [7:0]                    pixel,
  input  logic                          frame_start,
  input  logic [sg_pkg::CfgDataW-1:0]   line_width,
  input  logic [sg_pkg::CfgDataW-1:0]   frame_height,
  output sg_pkg::stage_t                dout
);
  localparam int AW = $clog2(MaxWidth);
  localparam int CW = $clog2(MaxWidth + 1) > 13 ? $clog2(MaxWidth + 1) : 13;

  // Stage A: pixel accepted, line stores read
  logic [CW-1:0] col, col_next, w_use;
  logic [12:0]   row, row_next, h_use;
  logic [CW-1:0] col_c;
  logic [12:0]   row_c;
  logic          a_vld, a_inr, a_emit, a_fend;
  logic [7:0]    a_px;
  logic [CW-1:0] a_col;
  logic [12:0]   a_row;
  logic [7:0]    top_rd, mid_rd, top_q, mid_q;
  logic          held;
  logic [7:0]    top, mid;
  logic [7:0]    win [6];
  logic          inr;
  logic [AW-1:0] a_addr;
  logic          top_we;
  logic          byp;
  logic [7:0]    byp_mid;

  always_comb begin
    w_use = (CW'(line_width) < CW'(3)) ? CW'(3) :
            (CW'(line_width) > CW'(MaxWidth)) ? CW'(MaxWidth) : CW'(line_width);
    h_use = (frame_height < 13'd3) ? 13'd3 :
            (frame_height > 13'd4096) ? 13'd4096 : frame_height;
    col_c = frame_start ? '0 : col;
    row_c = frame_start ? '0 : row;
    inr   = col_c < CW'(MaxWidth);
    col_next = col_c + CW'(1);
    row_next = row_c;
    if (col_next >= w_use) begin
      col_next = '0;
      row_next = row_c + 13'd1;
      if (row_next >= h_use) row_next = '0;
    end
  end

  // Top store takes the mid word read for its column, written in the following cycle
  assign top_we = a_vld && a_inr;

  // Mid store is read and written at the same column in one access
  sg_ram #(.Width(8), .Depth(MaxWidth)) u_top (
    .clk(clk), .we(top_we), .waddr(a_addr), .wdata(mid),
    .re(in_take && inr), .raddr(col_c[AW-1:0]), .rdata(top_rd));
  sg_ram #(.Width(8), .Depth(MaxWidth)) u_mid (
    .clk(clk), .we(in_take && inr), .waddr(col_c[AW-1:0]), .wdata(pixel),
    .re(in_take && inr), .raddr(col_c[AW-1:0]), .rdata(mid_rd));

  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row   <= '0;
      a_vld <= 1'b0;
    end else if (in_take) begin
      col   <= col_next;
      row   <= row_next;
      a_vld <= 1'b1;
    end else if (en) begin
      a_vld <= 1'b0;
    end
    if (in_take) begin
      a_px   <= pixel;
      a_inr  <= inr;
      a_col  <= col_c;
      a_row  <= row_c;
      a_addr <= col_c[AW-1:0];
      a_emit <= col_c >= CW'(2) && row_c >= 13'd2 && col_c < w_use && row_c < h_use;
      a_fend <= col_c == w_use - CW'(1) && row_c == h_use - 13'd1;
    end
  end

  // Read data is held when the chain stalls; a top read of the column being
  // written in the same cycle takes the word being written
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_take) begin
      held <= 1'b0;
    end else if (!en && a_vld && !held) begin
      held <= 1'b1;
    end
    if (!held) begin
      top_q <= top_rd;
      mid_q <= mid_rd;
    end
    if (in_take) begin
      byp     <= top_we && a_addr == col_c[AW-1:0];
      byp_mid <= mid;
    end
  end

  assign top = !a_inr ? 8'd0 : (byp ? byp_mid : (held ? top_q : top_rd));
  assign mid = !a_inr ? 8'd0 : (held ? mid_q : mid_rd);

  // Scharr sums on the full window
  logic signed [12:0] gx, gy;
  logic signed [12:0] l0, c0, r0, l1, r1, l2, c2, r2;
  logic signed [25:0] gx_w, gy_w;
  always_comb begin
    l0 = 13'(win[0]); c0 = 13'(win[1]); r0 = 13'(top);
    l1 = 13'(win[2]);                   r1 = 13'(mid);
    l2 = 13'(win[4]); c2 = 13'(win[5]); r2 = 13'(a_px);
    gx = 13'sd3 * (r0 - l0) + 13'sd10 * (r1 - l1) + 13'sd3 * (r2 - l2);
    gy = 13'sd3 * (l2 - l0) + 13'sd10 * (c2 - c0) + 13'sd3 * (r2 - r0);
    gx_w = 26'(gx);
    gy_w = 26'(gy);
  end

  logic signed [sg_pkg::XyW-1:0] x0, y0;
  logic signed [sg_pkg::ZW-1:0]  z0;
  always_comb begin
    x0 = sg_pkg::XyW'(gx) <<< 20;
    y0 = sg_pkg::XyW'(gy) <<< 20;
    z0 = '0;
    if (gx[12]) begin
      x0 = -x0;
      y0 = -y0;
      z0 = gy[12] ? -sg_pkg::PiQ30 : sg_pkg::PiQ30;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) win[i] <= 8'd0;
      dout.vld <= 1'b0;
    end else if (en) begin
      dout.vld <= a_vld && a_emit;
      if (a_vld) begin
        win[0] <= win[1]; win[1] <= top;
        win[2] <= win[3]; win[3] <= mid;
        win[4] <= win[5]; win[5] <= a_px;
      end
    end
    if (en) begin
      dout.x       <= x0;
      dout.y       <= y0;
      dout.z       <= z0;
      dout.zero    <= gx == 13'sd0 && gy == 13'sd0;
      dout.grad_sq <= 25'(gx_w * gx_w + gy_w * gy_w);
      dout.col     <= 12'(a_col - CW'(1));
      dout.row     <= 12'(a_row - 13'd1);
      dout.fend    <= a_fend;
    end
  end
endmodule

[sv/scharr_gradient_3x3_unit.sv]
// Streaming 3x3 Scharr gradient. One pixel word is taken per clock whenever
// the output side keeps pace; each pixel's result word passes through the
// load and window stages, the 30-cell CORDIC chain and the round stage.
// A stall on the output freezes the whole chain. Line stores are one RAM
// per row, indexed by column.
module scharr_gradient_3x3_unit #(
  parameter int MaxWidth      = sg_pkg::MaxWidthDefault,
  parameter int AngleFracBits = sg_pkg::AngleFracDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [sg_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [sg_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   pixel,
  input  logic                         frame_start,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [24:0]                  grad_sq,
  output logic signed [15:0]           direction,
  output logic [11:0]                  center_col,
  output logic [11:0]                  center_row,
  output logic                         frame_end
);
  localparam int Sh = 30 - AngleFracBits;

  logic [sg_pkg::CfgDataW-1:0] line_width, frame_height;
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= 13'd640;
      frame_height <= 13'd480;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sg_pkg::RegLineWidth:   line_width   <= cfg_data;
        sg_pkg::RegFrameHeight: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Chain advances unless a finished word is waiting and stalled
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  sg_pkg::stage_t chain [sg_pkg::CordicSteps + 1];

  sg_window #(.MaxWidth(MaxWidth)) u_win (
    .clk(clk), .rst(rst), .en(en), .in_take(in_valid && en),
    .pixel(pixel), .frame_start(frame_start),
    .line_width(line_width), .frame_height(frame_height), .dout(chain[0]));

  for (genvar i = 0; i < sg_pkg::CordicSteps; i++) begin : g_cell
    sg_cordic_cell #(.Step(i)) u_cell (
      .clk(clk), .rst(rst), .en(en), .din(chain[i]), .dout(chain[i+1]));
  end

  // Round to nearest, halves away from zero
  sg_pkg::stage_t last;
  logic signed [sg_pkg::ZW-1:0] za, zr;
  logic signed [sg_pkg::ZW-1:0] half;
  always_comb begin
    last = chain[sg_pkg::CordicSteps];
    half = sg_pkg::ZW'(1) <<< (Sh - 1);
    za   = last.z[sg_pkg::ZW-1] ? -last.z : last.z;
    zr   = (za + half) >>> Sh;
    if (last.z[sg_pkg::ZW-1]) zr = -zr;
    if (last.zero) zr = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= last.vld;
    end
    if (en) begin
      grad_sq    <= last.grad_sq;
      direction  <= zr[15:0];
      center_col <= last.col;
      center_row <= last.row;
      frame_end  <= last.fend;
    end
  end
endmodule
